// ===== hdl/srtfps_pkg.sv =====
// Shared types and constants of the SRTF process scheduler.
package srtfps_pkg;

	localparam int MAX_PROCS_DEF = 16;
	localparam int TIME_BITS_DEF = 16;

	localparam int ID_PORT_W   = 4;
	localparam int BURST_W     = 16;
	localparam int LEFT_PORT_W = 16;

	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_ARRIVE = 1'b1;

	typedef struct packed {
		logic clear;
		logic cand;
	} min_ctl_t;

endpackage

// ===== hdl/srtfps_table.sv =====
// Remaining-time memory: one write port, one registered read port.
module srtfps_table #(
	parameter int DEPTH = 16,
	parameter int DW    = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/srtfps_min.sv =====
// Shared comparator that tracks the least remaining time seen in a scan.
module srtfps_min import srtfps_pkg::*; #(
	parameter int IDX_W = 4,
	parameter int VAL_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  min_ctl_t         ctl,
	input  logic [IDX_W-1:0] idx,
	input  logic [VAL_W-1:0] val,
	output logic             found,
	output logic [IDX_W-1:0] best_idx,
	output logic [VAL_W-1:0] best_val
);

	logic take;

	assign take = ctl.cand && (!found || (val < best_val));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
		end else if (ctl.clear) begin
			found <= 1'b0;
		end else if (take) begin
			found <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clear && take) begin
			best_idx <= idx;
			best_val <= val;
		end
	end

endmodule

// ===== hdl/srtf_process_scheduler_unit.sv =====
// Shortest-remaining-time-first scheduler: top level with sequencer.
//
// Input channel (item_valid / item_stall) takes one word per item: an arrival
// (operation = 1) that admits arrive_id with burst_time if the id is in range and the
// burst is nonzero, or a tick (0) that charges one unit to the running process and then
// picks the present process with the least remaining time, lower id winning ties.
// Every item gives exactly one result word on the output channel
// (result_valid / result_stall).
// An arrival goes from the idle state straight to the emit step; a tick passes
// through a decrement step and then a scan that reads the remaining-time memory
// one entry a cycle through its single read port into one shared comparator,
// before its emit step.
// The input stalls from acceptance until the result is loaded into the output
// register; one result may wait there while the next item is taken.
// If the receiver stalls, the output word holds and a finished item waits in
// its last step until the register frees.
// Reset (arst_n low) empties the table, clears the running process and drops
// any pending result; no clearing pass is needed.
module srtf_process_scheduler_unit import srtfps_pkg::*; #(
	parameter int MAX_PROCS = MAX_PROCS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic                   operation,
	input  logic [ID_PORT_W-1:0]   arrive_id,
	input  logic [BURST_W-1:0]     burst_time,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic                   running_valid,
	output logic [ID_PORT_W-1:0]   running_id,
	output logic [LEFT_PORT_W-1:0] running_left,
	output logic                   switched,
	output logic                   first_dispatch,
	output logic                   finished_valid,
	output logic [ID_PORT_W-1:0]   finished_id
);

	localparam int ID_W  = $clog2(MAX_PROCS);
	localparam int CNT_W = $clog2(MAX_PROCS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DEC  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                 state_q;
	logic                   op_q;
	logic                   busy_q;
	logic [ID_W-1:0]        cur_q;
	logic [TIME_BITS-1:0]   left_q;
	logic [MAX_PROCS-1:0]   present_q;
	logic [MAX_PROCS-1:0]   started_q;
	logic                   fin_q;
	logic [ID_W-1:0]        fin_id_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   tv_s1;
	logic [ID_W-1:0]        tag_s1;

	logic                         accept;
	logic [ID_W+ID_PORT_W-1:0]    aid_ext;
	logic [ID_W-1:0]              aid;
	logic                         in_range;
	logic [TIME_BITS+BURST_W-1:0] bt_ext;
	logic [TIME_BITS-1:0]         bt;
	logic                         arr_ok;
	logic                         arr_run;
	logic [TIME_BITS-1:0]         dec_left;

	logic                 mem_we;
	logic [ID_W-1:0]      mem_waddr;
	logic [TIME_BITS-1:0] mem_wdata;
	logic                 rd_en;
	logic [TIME_BITS-1:0] rd_data;

	min_ctl_t             min_ctl;
	logic                 found;
	logic [ID_W-1:0]      best_idx;
	logic [TIME_BITS-1:0] best_val;

	logic                 slot_free;
	logic                 emit;
	logic                 take;
	logic                 sw;
	logic                 first;
	logic                 nbusy;
	logic [ID_W-1:0]      ncur;
	logic [TIME_BITS-1:0] nleft;

	logic [ID_W+ID_PORT_W-1:0]        ncur_ext;
	logic [ID_W+ID_PORT_W-1:0]        fin_ext;
	logic [TIME_BITS+LEFT_PORT_W-1:0] nleft_ext;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	assign aid_ext  = {{ID_W{1'b0}}, arrive_id};
	assign aid      = aid_ext[ID_W-1:0];
	assign in_range = 32'(arrive_id) < MAX_PROCS;
	assign bt_ext   = {{TIME_BITS{1'b0}}, burst_time};
	assign bt       = bt_ext[TIME_BITS-1:0];
	assign arr_ok   = in_range && (bt != '0);
	assign arr_run  = busy_q && (cur_q == aid);
	assign dec_left = left_q - TIME_BITS'(1);

	assign mem_we    = (accept && (operation == OP_ARRIVE) && arr_ok) ||
	                   ((state_q == ST_DEC) && busy_q);
	assign mem_waddr = (state_q == ST_DEC) ? cur_q : aid;
	assign mem_wdata = (state_q == ST_DEC) ? dec_left : bt;
	assign rd_en     = (state_q == ST_SCAN) && (cnt_q < CNT_W'(MAX_PROCS));

	srtfps_table #(
		.DEPTH (MAX_PROCS),
		.DW    (TIME_BITS)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (rd_en),
		.raddr (cnt_q[ID_W-1:0]),
		.rdata (rd_data)
	);

	assign min_ctl.clear = (state_q == ST_DEC);
	assign min_ctl.cand  = tv_s1 && present_q[tag_s1];

	srtfps_min #(
		.IDX_W (ID_W),
		.VAL_W (TIME_BITS)
	) u_min (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (min_ctl),
		.idx      (tag_s1),
		.val      (rd_data),
		.found    (found),
		.best_idx (best_idx),
		.best_val (best_val)
	);

	assign slot_free = !result_valid || !result_stall;
	assign emit      = (state_q == ST_EMIT) && slot_free;
	assign take      = (op_q == OP_TICK) && found;
	assign sw        = take && (!busy_q || (cur_q != best_idx));
	assign first     = sw && !started_q[best_idx];
	assign nbusy     = take ? 1'b1 : busy_q;
	assign ncur      = take ? best_idx : cur_q;
	assign nleft     = take ? best_val : left_q;

	assign ncur_ext  = {{ID_PORT_W{1'b0}}, ncur};
	assign fin_ext   = {{ID_PORT_W{1'b0}}, fin_id_q};
	assign nleft_ext = {{LEFT_PORT_W{1'b0}}, nleft};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			op_q      <= OP_TICK;
			busy_q    <= 1'b0;
			cur_q     <= '0;
			left_q    <= '0;
			present_q <= '0;
			started_q <= '0;
			fin_q     <= 1'b0;
			cnt_q     <= '0;
			tv_s1     <= 1'b0;
		end else begin
			tv_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= operation;
						fin_q <= 1'b0;
						if (operation == OP_ARRIVE) begin
							if (arr_ok) begin
								present_q[aid] <= 1'b1;
								if (arr_run) begin
									left_q <= bt;
								end else begin
									started_q[aid] <= 1'b0;
								end
							end
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_DEC;
						end
					end
				end
				ST_DEC: begin
					if (busy_q) begin
						left_q <= dec_left;
						if (dec_left == '0) begin
							present_q[cur_q] <= 1'b0;
							busy_q           <= 1'b0;
							fin_q            <= 1'b1;
						end
					end
					cnt_q   <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(MAX_PROCS)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						busy_q <= nbusy;
						cur_q  <= ncur;
						left_q <= nleft;
						if (take) begin
							started_q[best_idx] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= cnt_q[ID_W-1:0];
		if (state_q == ST_DEC) begin
			fin_id_q <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			running_valid  <= nbusy;
			running_id     <= nbusy ? ncur_ext[ID_PORT_W-1:0] : '0;
			running_left   <= nbusy ? nleft_ext[LEFT_PORT_W-1:0] : '0;
			switched       <= sw;
			first_dispatch <= first;
			finished_valid <= fin_q;
			finished_id    <= fin_q ? fin_ext[ID_PORT_W-1:0] : '0;
		end
	end

endmodule

// ===== hdl/srtfps_checker.sv =====
// Port-level checks of the SRTF scheduler and their binding to the top level.
module srtfps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        running_valid,
	input logic [3:0]  running_id,
	input logic [15:0] running_left,
	input logic        switched,
	input logic        first_dispatch,
	input logic        finished_valid,
	input logic [3:0]  finished_id
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input not stalled after a word was taken");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !running_valid |-> running_id == 4'd0 && running_left == 16'd0)
		else $error("idle result carries a process");

	a_switch_needs_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (switched || first_dispatch) |-> running_valid && switched)
		else $error("switch or first dispatch without a running process");

	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && running_valid |-> running_left != 16'd0)
		else $error("running process shows no remaining time");

	a_fin_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !finished_valid |-> finished_id == 4'd0)
		else $error("finished id set without completion");

endmodule

bind srtf_process_scheduler_unit srtfps_checker u_srtfps_checker (.*);
